FILE: hdl/stba_pkg.sv
// Shared types and constants for the simulation time barrier.
// Used by stba_ctrl, stba_dp and sim_time_barrier_advance; no dependencies.
package stba_pkg;

    localparam int MAX_CLIENTS = 16;
    localparam int IDX_W       = $clog2(MAX_CLIENTS);
    localparam int ID_W        = 16;
    localparam int TIME_W      = 64;

    typedef enum logic [1:0] {
        FN_REQUEST    = 2'd0,
        FN_REGISTER   = 2'd1,
        FN_UNREGISTER = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_STALE    = 3'd1,
        ST_UNKNOWN  = 3'd2,
        ST_FULL     = 3'd3,
        ST_RESERVED = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_FIND,
        S_MIN,
        S_ADV,
        S_CLEAR,
        S_REG,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load;
        logic    idx_clear;
        logic    idx_set_one;
        logic    idx_inc;
        logic    req_write;
        logic    do_register;
        logic    do_unregister;
        logic    min_step;
        logic    clock_update;
        logic    clear_step;
        logic    set_status;
        status_t status_code;
        logic    out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        func_t func;
        logic  id_zero;
        logic  idx_last;
        logic  hit;
        logic  stale;
        logic  used;
        logic  pending;
        logic  have;
        logic  out_free;
    } dp_stat_t;

endpackage

FILE: hdl/stba_ctrl.sv
// Controller state machine for the simulation time barrier.
// Depends on stba_pkg; drives stba_dp through dp_cmd_t and reads dp_stat_t.
module stba_ctrl
    import stba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.status_code = ST_OK;
        in_ready        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.func)
                    FN_REQUEST:
                    begin
                        state_next = S_FIND;
                    end
                    FN_REGISTER:
                    begin
                        state_next = S_REG;
                    end
                    FN_UNREGISTER:
                    begin
                        if (stat.id_zero)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_RESERVED;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            // slot 0 holds the reserved client; start past it
                            cmd.idx_set_one = 1'b1;
                            state_next      = S_FIND;
                        end
                    end
                    default:
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_UNKNOWN;
                        state_next      = S_DONE;
                    end
                endcase
            end
            S_FIND:
            begin
                if (stat.hit)
                begin
                    if (stat.func == FN_REQUEST)
                    begin
                        if (stat.stale)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_STALE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            cmd.req_write = 1'b1;
                            cmd.idx_clear = 1'b1;
                            state_next    = S_MIN;
                        end
                    end
                    else
                    begin
                        cmd.do_unregister = 1'b1;
                        state_next        = S_DONE;
                    end
                end
                else if (stat.idx_last)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_UNKNOWN;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_MIN:
            begin
                cmd.min_step = 1'b1;
                if (stat.used && !stat.pending)
                begin
                    // someone still owes a request: no barrier
                    state_next = S_DONE;
                end
                else if (stat.idx_last)
                begin
                    state_next = S_ADV;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_ADV:
            begin
                if (stat.have)
                begin
                    cmd.clock_update = 1'b1;
                    cmd.idx_clear    = 1'b1;
                    state_next       = S_CLEAR;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_REG:
            begin
                cmd.do_register = 1'b1;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/stba_dp.sv
// Datapath for the simulation time barrier: client table, scan index,
// minimum tracker, simulation clock and output register. Depends on stba_pkg.
module stba_dp
    import stba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        func,
    input  logic [ID_W-1:0]   client,
    input  logic [TIME_W-1:0] target_time,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic [ID_W-1:0]   assigned_id,
    output logic              advanced,
    output logic [TIME_W-1:0] sim_time_now
);

    // captured item
    func_t             func_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] time_reg;

    // client table
    logic              slot_used_reg    [MAX_CLIENTS];
    logic              slot_pending_reg [MAX_CLIENTS];
    logic [ID_W-1:0]   slot_client_reg  [MAX_CLIENTS];
    logic [TIME_W-1:0] slot_request_reg [MAX_CLIENTS];

    logic [IDX_W-1:0]  idx_reg;
    logic [TIME_W-1:0] lo_reg;
    logic              have_reg;
    logic [TIME_W-1:0] sim_clock_reg;
    logic [ID_W-1:0]   next_id_reg;

    status_t           res_status_reg;
    logic [ID_W-1:0]   res_assigned_reg;
    logic              res_adv_reg;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [ID_W-1:0]   out_assigned_reg;
    logic              out_adv_reg;
    logic [TIME_W-1:0] out_time_reg;

    logic              cur_used;
    logic              cur_pending;
    logic [TIME_W-1:0] cur_request;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    logic [ID_W-1:0]   new_id;
    logic              reg_ok;

    assign cur_used    = slot_used_reg[idx_reg];
    assign cur_pending = slot_pending_reg[idx_reg];
    assign cur_request = slot_request_reg[idx_reg];
    assign new_id      = next_id_reg + ID_W'(1);

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_CLIENTS - 1; i >= 0; i--)
        begin
            if (!slot_used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign reg_ok = free_found && (next_id_reg != '1);

    always_comb
    begin
        stat.func     = func_reg;
        stat.id_zero  = (id_reg == '0);
        stat.idx_last = (idx_reg == IDX_W'(MAX_CLIENTS - 1));
        stat.hit      = cur_used && (slot_client_reg[idx_reg] == id_reg);
        stat.stale    = (time_reg <= cur_request);
        stat.used     = cur_used;
        stat.pending  = cur_pending;
        stat.have     = have_reg;
        stat.out_free = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CLIENTS; i++)
            begin
                slot_used_reg[i]    <= (i == 0);
                slot_pending_reg[i] <= 1'b0;
                slot_client_reg[i]  <= '0;
                slot_request_reg[i] <= '0;
            end
            idx_reg          <= '0;
            lo_reg           <= '0;
            have_reg         <= 1'b0;
            sim_clock_reg    <= '0;
            next_id_reg      <= '0;
            res_status_reg   <= ST_OK;
            res_assigned_reg <= '0;
            res_adv_reg      <= 1'b0;
            func_reg         <= FN_REQUEST;
            id_reg           <= '0;
            time_reg         <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                func_reg         <= func_t'(func);
                id_reg           <= client;
                time_reg         <= target_time;
                have_reg         <= 1'b0;
                res_status_reg   <= ST_OK;
                res_assigned_reg <= '0;
                res_adv_reg      <= 1'b0;
            end

            if (cmd.load || cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_set_one)
            begin
                idx_reg <= IDX_W'(1);
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end

            if (cmd.set_status)
            begin
                res_status_reg <= cmd.status_code;
            end

            if (cmd.req_write)
            begin
                slot_request_reg[idx_reg] <= time_reg;
                slot_pending_reg[idx_reg] <= 1'b1;
            end

            if (cmd.do_unregister)
            begin
                slot_used_reg[idx_reg]    <= 1'b0;
                slot_pending_reg[idx_reg] <= 1'b0;
                slot_client_reg[idx_reg]  <= '0;
                slot_request_reg[idx_reg] <= '0;
            end

            if (cmd.do_register)
            begin
                if (reg_ok)
                begin
                    next_id_reg                <= new_id;
                    slot_used_reg[free_idx]    <= 1'b1;
                    slot_pending_reg[free_idx] <= 1'b0;
                    slot_client_reg[free_idx]  <= new_id;
                    slot_request_reg[free_idx] <= '0;
                    res_assigned_reg           <= new_id;
                end
                else
                begin
                    res_status_reg <= ST_FULL;
                end
            end

            // track the smallest pending request
            if (cmd.min_step && cur_used && cur_pending && (!have_reg || cur_request < lo_reg))
            begin
                lo_reg   <= cur_request;
                have_reg <= 1'b1;
            end

            if (cmd.clock_update && (lo_reg > sim_clock_reg))
            begin
                sim_clock_reg <= lo_reg;
                res_adv_reg   <= 1'b1;
            end

            // drop the pending mark of every client at or below the minimum
            if (cmd.clear_step && cur_used && (cur_request <= lo_reg))
            begin
                slot_pending_reg[idx_reg] <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg   <= res_status_reg;
            out_assigned_reg <= res_assigned_reg;
            out_adv_reg      <= res_adv_reg;
            out_time_reg     <= sim_clock_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign assigned_id  = out_assigned_reg;
    assign advanced     = out_adv_reg;
    assign sim_time_now = out_time_reg;

`ifndef SYNTH
    a_slot0_used: assert property (@(posedge clk) disable iff (!rst_n)
        slot_used_reg[0] && slot_client_reg[0] == '0)
        else $error("reserved slot lost");

    a_clock_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> sim_clock_reg >= $past(sim_clock_reg))
        else $error("simulation clock moved backward");

    a_adv_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && res_adv_reg |-> res_status_reg == ST_OK)
        else $error("advance reported with error status");

    a_assigned_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && res_assigned_reg != '0 |->
            res_status_reg == ST_OK && res_assigned_reg == next_id_reg)
        else $error("assigned id inconsistent");
`endif

endmodule

FILE: hdl/sim_time_barrier_advance.sv
// Simulation time barrier: clients post strictly increasing time requests;
// the shared clock advances to the minimum, if later, once every client is pending.
// A time request makes up to three scans of the 16-slot table (lookup, minimum,
// clear); unregister makes one lookup scan from slot 1, register none at all.
// One word at a time; the next word is taken in the cycle after the result loads
// the output register, once the prior result is taken. Async active-low reset.
module sim_time_barrier_advance
    import stba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        func,
    input  logic [ID_W-1:0]   client,
    input  logic [TIME_W-1:0] target_time,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic [ID_W-1:0]   assigned_id,
    output logic              advanced,
    output logic [TIME_W-1:0] sim_time_now
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    stba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    stba_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .func         (func),
        .client       (client),
        .target_time  (target_time),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .assigned_id  (assigned_id),
        .advanced     (advanced),
        .sim_time_now (sim_time_now)
    );

endmodule
